[hw/rtl/sym3_pkg.sv]
`default_nettype none
package sym3_pkg;

  localparam int DATA_W        = 32;
  localparam int N_ENT         = 6;
  localparam int N_PROD        = 12;
  localparam int PROD_W        = 2 * DATA_W;
  localparam int COF_W         = PROD_W + 1;
  localparam int DET_W         = 98;
  localparam int FRAC_BITS_DEF = 16;
  localparam int FIFO_DEPTH    = 8;
  localparam int FIFO_AW       = $clog2(FIFO_DEPTH);
  localparam int APB_AW        = 3;
  localparam int APB_DW        = 32;

  // word index of each configuration register
  localparam logic REG_COPY_ONLY = 1'b0;

  typedef struct packed {
    logic                              copy;
    logic [N_ENT-1:0][COF_W-1:0]       cof;
    logic [DET_W-1:0]                  det;
  } front_item_t;

endpackage
`default_nettype wire

[hw/rtl/sym3_front.sv]
`default_nettype none
module sym3_front (
  input  wire logic                                             clk_i,
  input  wire logic                                             rst_ni,
  input  wire logic                                             in_valid_i,
  input  wire logic                                             in_copy_i,
  input  wire logic [sym3_pkg::N_ENT-1:0][sym3_pkg::DATA_W-1:0] in_g_i,
  output logic                                                  out_valid_o,
  output sym3_pkg::front_item_t                                 out_item_o
);

  localparam int DW = sym3_pkg::DATA_W;
  localparam int PW = sym3_pkg::PROD_W;
  localparam int CW = sym3_pkg::COF_W;
  localparam int TW = sym3_pkg::DET_W;
  localparam int NE = sym3_pkg::N_ENT;
  localparam int NP = sym3_pkg::N_PROD;

  logic signed [DW-1:0] g [NE];

  logic                 v1_q, v2_q, v3_q, v4_q;
  logic                 copy1_q, copy2_q, copy3_q, copy4_q;
  logic signed [DW-1:0] g1_q [NE];
  logic signed [PW-1:0] p1_d [NP];
  logic signed [PW-1:0] p1_q [NP];
  logic signed [DW-1:0] a2_q [3];
  logic signed [CW-1:0] cof2_d [NE];
  logic signed [CW-1:0] cof2_q [NE];
  logic signed [CW-1:0] cof3_q [NE];
  logic signed [CW-1:0] pp3_d [NE];
  logic signed [CW-1:0] pp3_q [NE];
  logic signed [CW-1:0] cof4_q [NE];
  logic signed [TW-1:0] det4_d;
  logic signed [TW-1:0] det4_q;

  always_comb begin
    for (int k = 0; k < NE; k++) begin
      g[k] = in_g_i[k];
    end
  end

  // pairwise products: g11 g12 g13 g22 g23 g33 sit at 0..5
  always_comb begin
    p1_d[0]  = g[3] * g[5];
    p1_d[1]  = g[4] * g[4];
    p1_d[2]  = g[2] * g[4];
    p1_d[3]  = g[1] * g[5];
    p1_d[4]  = g[1] * g[4];
    p1_d[5]  = g[2] * g[3];
    p1_d[6]  = g[0] * g[5];
    p1_d[7]  = g[2] * g[2];
    p1_d[8]  = g[2] * g[1];
    p1_d[9]  = g[0] * g[4];
    p1_d[10] = g[0] * g[3];
    p1_d[11] = g[1] * g[1];
  end

  always_comb begin
    for (int k = 0; k < NE; k++) begin
      if (copy1_q) begin
        cof2_d[k] = CW'(g1_q[k]);
      end else begin
        cof2_d[k] = CW'(p1_q[2*k]) - CW'(p1_q[2*k+1]);
      end
    end
  end

  // split each first-row cofactor into a signed high and an unsigned low half
  always_comb begin
    logic signed [DW:0] hi;
    logic signed [DW:0] lo;
    for (int j = 0; j < 3; j++) begin
      hi = $signed(cof2_q[j][CW-1:DW]);
      lo = $signed({1'b0, cof2_q[j][DW-1:0]});
      pp3_d[2*j]   = hi * a2_q[j];
      pp3_d[2*j+1] = lo * a2_q[j];
    end
  end

  always_comb begin
    logic signed [TW-1:0] acc;
    acc = '0;
    for (int j = 0; j < 3; j++) begin
      acc = acc + (TW'(pp3_q[2*j]) <<< DW) + TW'(pp3_q[2*j+1]);
    end
    det4_d = acc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    copy1_q <= in_copy_i;
    copy2_q <= copy1_q;
    copy3_q <= copy2_q;
    copy4_q <= copy3_q;
    for (int k = 0; k < NE; k++) begin
      g1_q[k]   <= g[k];
      cof2_q[k] <= cof2_d[k];
      cof3_q[k] <= cof2_q[k];
      pp3_q[k]  <= pp3_d[k];
      cof4_q[k] <= cof3_q[k];
    end
    for (int k = 0; k < NP; k++) begin
      p1_q[k] <= p1_d[k];
    end
    for (int j = 0; j < 3; j++) begin
      a2_q[j] <= g1_q[j];
    end
    det4_q <= det4_d;
  end

  always_comb begin
    out_valid_o     = v4_q;
    out_item_o.copy = copy4_q;
    out_item_o.det  = det4_q;
    for (int k = 0; k < NE; k++) begin
      out_item_o.cof[k] = cof4_q[k];
    end
  end

endmodule
`default_nettype wire

[hw/rtl/sym3_fifo.sv]
`default_nettype none
module sym3_fifo (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire sym3_pkg::front_item_t data_i,
  input  wire logic                  pop_i,
  output sym3_pkg::front_item_t      data_o,
  output logic                       empty_o,
  output logic                       full_o
);

  localparam int AW = sym3_pkg::FIFO_AW;

  sym3_pkg::front_item_t mem_q [sym3_pkg::FIFO_DEPTH];
  logic [AW-1:0]         wr_ptr_q, rd_ptr_q;
  logic [AW:0]           cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (AW+1)'(sym3_pkg::FIFO_DEPTH));
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i)) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue read while empty");
`endif

endmodule
`default_nettype wire

[hw/rtl/sym3_back.sv]
`default_nettype none
module sym3_back #(
  parameter int FRAC_BITS = sym3_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        rst_ni,
  input  wire logic                                        in_valid_i,
  input  wire sym3_pkg::front_item_t                       in_item_i,
  output logic                                             in_pop_o,
  input  wire logic                                        out_ready_i,
  output logic                                             out_valid_o,
  output logic [sym3_pkg::N_ENT-1:0][sym3_pkg::DATA_W-1:0] out_h_o,
  output logic                                             out_singular_o,
  output logic                                             out_saturated_o
);

  localparam int CW = sym3_pkg::COF_W;
  localparam int DW = sym3_pkg::DET_W;
  localparam int QW = sym3_pkg::DATA_W;
  localparam int NE = sym3_pkg::N_ENT;
  localparam int NW = CW + 2 * FRAC_BITS;
  localparam int RW = (NW > DW) ? NW : DW;
  localparam int NS = QW;

  logic en;

  // operand preparation
  logic                  b1_v_q, b1_copy_q, b1_zero_q;
  logic [DW-1:0]         b1_dabs_d, b1_dabs_q;
  logic [NE-1:0]         b1_neg_d, b1_neg_q;
  logic [CW-1:0]         b1_mag_d [NE];
  logic [CW-1:0]         b1_mag_q [NE];

  // division pipeline, index 0 holds the numerators, scaled except in copy mode
  logic                  v_q    [NS+1];
  logic                  copy_q [NS+1];
  logic                  zero_q [NS+1];
  logic [DW-1:0]         d_q    [NS+1];
  logic [NE-1:0]         neg_q  [NS+1];
  logic [NE-1:0]         over_q [NS+1];
  logic [RW-1:0]         rem_q  [NS+1][NE];
  logic [QW-1:0]         quo_q  [NS+1][NE];
  logic [RW-1:0]         num_d  [NE];
  logic [NE-1:0]         over_d;

  logic                  out_v_q;
  logic [NE-1:0][QW-1:0] h_d, h_q;
  logic                  sing_d, sing_q, sat_d, sat_q;

  assign en       = !out_v_q || out_ready_i;
  assign in_pop_o = en && in_valid_i;

  always_comb begin
    logic signed [DW-1:0] det;
    logic signed [CW-1:0] cof;
    det = $signed(in_item_i.det);
    b1_dabs_d = det[DW-1] ? DW'(-det) : DW'(det);
    for (int k = 0; k < NE; k++) begin
      cof = $signed(in_item_i.cof[k]);
      if (in_item_i.copy) begin
        b1_mag_d[k] = {{(CW-QW){1'b0}}, in_item_i.cof[k][QW-1:0]};
        b1_neg_d[k] = 1'b0;
      end else begin
        b1_mag_d[k] = cof[CW-1] ? CW'(-cof) : CW'(cof);
        b1_neg_d[k] = cof[CW-1] ^ det[DW-1];
      end
    end
    if (in_item_i.copy) begin
      b1_dabs_d = '1;
    end
  end

  always_comb begin
    for (int k = 0; k < NE; k++) begin
      if (b1_copy_q) begin
        num_d[k]  = RW'(b1_mag_q[k]);
        over_d[k] = 1'b0;
      end else begin
        num_d[k]  = RW'(b1_mag_q[k]) << (2 * FRAC_BITS);
        over_d[k] = (num_d[k] >> QW) >= RW'(b1_dabs_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q  <= 1'b0;
      v_q[0]  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      b1_v_q  <= in_valid_i;
      v_q[0]  <= b1_v_q;
      out_v_q <= v_q[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b1_copy_q <= in_item_i.copy;
      b1_zero_q <= (in_item_i.det == '0);
      b1_dabs_q <= b1_dabs_d;
      b1_neg_q  <= b1_neg_d;
      copy_q[0] <= b1_copy_q;
      zero_q[0] <= b1_zero_q;
      d_q[0]    <= b1_dabs_q;
      neg_q[0]  <= b1_neg_q;
      over_q[0] <= over_d;
      for (int k = 0; k < NE; k++) begin
        b1_mag_q[k] <= b1_mag_d[k];
        rem_q[0][k] <= num_d[k];
        quo_q[0][k] <= '0;
      end
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_step
    localparam int BI = NS - 1 - s;
    logic [RW-1:0] rem_n [NE];
    logic [QW-1:0] quo_n [NE];

    always_comb begin
      for (int k = 0; k < NE; k++) begin
        rem_n[k] = rem_q[s][k];
        quo_n[k] = quo_q[s][k];
        if ((rem_q[s][k] >> BI) >= RW'(d_q[s])) begin
          rem_n[k]     = rem_q[s][k] - (RW'(d_q[s]) << BI);
          quo_n[k][BI] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s+1] <= 1'b0;
      end else if (en) begin
        v_q[s+1] <= v_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        copy_q[s+1] <= copy_q[s];
        zero_q[s+1] <= zero_q[s];
        d_q[s+1]    <= d_q[s];
        neg_q[s+1]  <= neg_q[s];
        over_q[s+1] <= over_q[s];
        for (int k = 0; k < NE; k++) begin
          rem_q[s+1][k] <= rem_n[k];
          quo_q[s+1][k] <= quo_n[k];
        end
      end
    end
  end

  // clip, apply sign, flag
  always_comb begin
    logic [QW-1:0] lim;
    logic [QW-1:0] val;
    logic          clip;
    sat_d  = 1'b0;
    sing_d = zero_q[NS] && !copy_q[NS];
    for (int k = 0; k < NE; k++) begin
      lim  = neg_q[NS][k] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
      clip = over_q[NS][k] || (quo_q[NS][k] > lim);
      val  = clip ? lim : quo_q[NS][k];
      if (copy_q[NS]) begin
        h_d[k] = rem_q[NS][k][QW-1:0];
      end else if (zero_q[NS]) begin
        h_d[k] = '0;
      end else begin
        h_d[k] = neg_q[NS][k] ? QW'(-val) : val;
        sat_d  = sat_d || clip;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      h_q    <= h_d;
      sing_q <= sing_d;
      sat_q  <= sat_d;
    end
  end

  assign out_valid_o     = out_v_q;
  assign out_h_o         = h_q;
  assign out_singular_o  = sing_q;
  assign out_saturated_o = sat_q;

endmodule
`default_nettype wire

[hw/rtl/symmetric_3x3_inverse_core.sv]
// Symmetric 3x3 matrix inverse, one matrix per transaction.
// Input stream: s_axis tdata carries g11 g12 g13 g22 g23 g33 (signed fixed
// point, FRAC_BITS fraction bits), 32 bits each from the lowest bit up.
// Output stream: m_axis tdata carries h11 h12 h13 h22 h23 h33 in the same
// format; tuser bit 0 is singular (entries zero), bit 1 is saturated.
// APB register at byte address 0, bit 0: copy_only, passes entries through.
// Write it only while no transaction is in flight.
// One transaction per cycle is sustained while the output is not stalled.
// The back end is a 32-step restoring divider, one quotient bit a stage,
// six lanes wide, behind four stages of products, cofactors and determinant.
// A stalled receiver freezes the divider; the front keeps draining into an
// 8-entry queue, and s_axis_tready drops once 8 transactions are held.
// Reset clears all valid state and copy_only; outputs are then idle.
`default_nettype none
module symmetric_3x3_inverse_core #(
  parameter int FRAC_BITS = sym3_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // g11, g12, g13, g22, g23, g33
  input  wire logic [191:0]                  s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // h11, h12, h13, h22, h23, h33
  output logic [191:0]                       m_axis_tdata_o,
  // singular, saturated
  output logic [1:0]                         m_axis_tuser_o,
  input  wire logic                          psel_i,
  input  wire logic                          penable_i,
  input  wire logic                          pwrite_i,
  input  wire logic [sym3_pkg::APB_AW-1:0]   paddr_i,
  input  wire logic [sym3_pkg::APB_DW-1:0]   pwdata_i,
  output logic [sym3_pkg::APB_DW-1:0]        prdata_o,
  output logic                               pready_o
);

  localparam int OW = sym3_pkg::FIFO_AW + 1;

  logic                  copy_only_q;
  logic [OW-1:0]         occ_q, occ_d;
  logic                  in_acc;
  logic                  front_valid;
  sym3_pkg::front_item_t front_item, fifo_item;
  logic                  fifo_empty, fifo_full, fifo_pop;
  logic [sym3_pkg::N_ENT-1:0][sym3_pkg::DATA_W-1:0] in_g, out_h;
  logic                  sing, sat;

  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i[2] == sym3_pkg::REG_COPY_ONLY) ?
                    {{(sym3_pkg::APB_DW-1){1'b0}}, copy_only_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      copy_only_q <= 1'b0;
    end else if (psel_i && penable_i && pwrite_i &&
                 paddr_i[2] == sym3_pkg::REG_COPY_ONLY) begin
      copy_only_q <= pwdata_i[0];
    end
  end

  // hold a slot for every transaction between acceptance and queue read
  assign s_axis_tready_o = (occ_q < OW'(sym3_pkg::FIFO_DEPTH));
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    occ_d = occ_q;
    if (in_acc && !fifo_pop) begin
      occ_d = occ_q + 1'b1;
    end else if (fifo_pop && !in_acc) begin
      occ_d = occ_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  assign in_g = s_axis_tdata_i;

  sym3_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_acc),
    .in_copy_i   (copy_only_q),
    .in_g_i      (in_g),
    .out_valid_o (front_valid),
    .out_item_o  (front_item)
  );

  sym3_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .data_i  (front_item),
    .pop_i   (fifo_pop),
    .data_o  (fifo_item),
    .empty_o (fifo_empty),
    .full_o  (fifo_full)
  );

  sym3_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (!fifo_empty),
    .in_item_i       (fifo_item),
    .in_pop_o        (fifo_pop),
    .out_ready_i     (m_axis_tready_i),
    .out_valid_o     (m_axis_tvalid_o),
    .out_h_o         (out_h),
    .out_singular_o  (sing),
    .out_saturated_o (sat)
  );

  assign m_axis_tdata_o = out_h;
  assign m_axis_tuser_o = {sat, sing};

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OW'(sym3_pkg::FIFO_DEPTH))
    else $error("occupancy exceeds queue depth");
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_full |-> !s_axis_tready_o)
    else $error("ready while queue full");
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tuser_o[0] && m_axis_tuser_o[1]))
    else $error("singular and saturated both set");
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q == '0 |-> s_axis_tready_o) else $error("not ready while empty");
`endif

endmodule
`default_nettype wire

[bench/sym3_inverse_checker.sv]
`timescale 1ns / 100ps
`default_nettype none
module sym3_inverse_checker (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         copy_only_i,
  input  wire logic         s_tvalid_i,
  input  wire logic         s_tready_i,
  input  wire logic [191:0] s_tdata_i,
  input  wire logic         m_tvalid_i,
  input  wire logic         m_tready_i,
  input  wire logic [191:0] m_tdata_i,
  input  wire logic [1:0]   m_tuser_i,
  output int                fail_count_o,
  output int                pending_o
);

  localparam int FRAC = sym3_pkg::FRAC_BITS_DEF;

  typedef struct packed {
    logic [1:0]   flags;
    logic [191:0] ent;
  } inverse_t;

  inverse_t inverse_q[$];

  function automatic inverse_t invert(input logic [191:0] g, input logic copy);
    inverse_t r;
    logic signed [63:0]  a [6];
    logic signed [129:0] cof [6];
    logic signed [129:0] det, num, dabs, q;
    logic neg, sat;
    r.ent = g;
    r.flags = 2'b00;
    if (copy) return r;
    for (int k = 0; k < 6; k++) a[k] = $signed(g[32*k +: 32]);
    // a: 0=g11 1=g12 2=g13 3=g22 4=g23 5=g33
    cof[0] = a[3]*a[5] - a[4]*a[4];
    cof[1] = a[2]*a[4] - a[1]*a[5];
    cof[2] = a[1]*a[4] - a[2]*a[3];
    cof[3] = a[0]*a[5] - a[2]*a[2];
    cof[4] = a[2]*a[1] - a[0]*a[4];
    cof[5] = a[0]*a[3] - a[1]*a[1];
    det = a[0]*cof[0] + a[1]*cof[1] + a[2]*cof[2];
    if (det == 0) begin
      r.ent = '0;
      r.flags = 2'b01;
      return r;
    end
    dabs = det < 0 ? -det : det;
    sat = 1'b0;
    for (int k = 0; k < 6; k++) begin
      neg = (cof[k] < 0) != (det < 0);
      num = cof[k] < 0 ? -cof[k] : cof[k];
      q = (num <<< (2*FRAC)) / dabs;
      if (!neg && q > 130'sh7FFFFFFF) begin
        q = 130'sh7FFFFFFF;
        sat = 1'b1;
      end else if (neg && q > 130'sh80000000) begin
        q = 130'sh80000000;
        sat = 1'b1;
      end
      if (neg) q = -q;
      r.ent[32*k +: 32] = q[31:0];
    end
    r.flags = {sat, 1'b0};
    return r;
  endfunction

  always @(posedge clk_i) begin
    inverse_t exp_r;
    if (!rst_ni) begin
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (s_tvalid_i && s_tready_i) inverse_q.push_back(invert(s_tdata_i, copy_only_i));
      if (m_tvalid_i && m_tready_i) begin
        if (inverse_q.size() == 0) begin
          $display("%0t: unexpected result %h %b", $time, m_tdata_i, m_tuser_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = inverse_q.pop_front();
          if (exp_r.ent !== m_tdata_i || exp_r.flags !== m_tuser_i) begin
            $display("%0t: expected %h %b, got %h %b", $time, exp_r.ent, exp_r.flags,
                     m_tdata_i, m_tuser_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      pending_o <= inverse_q.size();
    end
  end

endmodule
`default_nettype wire

[bench/tb_symmetric_3x3_inverse_core.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb_symmetric_3x3_inverse_core;

  logic clk, rst_n;
  logic s_tvalid, s_tready, m_tvalid, m_tready;
  logic [191:0] s_tdata, m_tdata;
  logic [1:0] m_tuser;
  logic psel, penable, pwrite;
  logic [sym3_pkg::APB_AW-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic copy_only;
  int fail_count, pending, cycles;
  logic hold_req;

  symmetric_3x3_inverse_core dut (
    .clk_i(clk), .rst_ni(rst_n),
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_o(s_tready), .s_axis_tdata_i(s_tdata),
    .m_axis_tvalid_o(m_tvalid), .m_axis_tready_i(m_tready),
    .m_axis_tdata_o(m_tdata), .m_axis_tuser_o(m_tuser),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .prdata_o(prdata), .pready_o(pready)
  );

  sym3_inverse_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n), .copy_only_i(copy_only),
    .s_tvalid_i(s_tvalid), .s_tready_i(s_tready), .s_tdata_i(s_tdata),
    .m_tvalid_i(m_tvalid), .m_tready_i(m_tready), .m_tdata_i(m_tdata),
    .m_tuser_i(m_tuser), .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 400000) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off
  initial begin
    int wait_n;
    bit held;
    held = 1'b0;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
        m_tready <= 1'b1;
      end else if (m_tready && !m_tvalid) begin
        m_tready <= 1'b1;
      end else if (m_tready && m_tvalid) begin
        wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
        if (wait_n == 0) m_tready <= 1'b1;
        else begin
          m_tready <= 1'b0;
          repeat (wait_n) @(posedge clk);
          m_tready <= 1'b1;
        end
      end else m_tready <= 1'b1;
    end
  end

  task automatic apb_write(input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= sym3_pkg::APB_AW'(4 * sym3_pkg::REG_COPY_ONLY); pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    copy_only <= value[0];
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic send_matrix(input logic [191:0] g, input bit gaps);
    int wait_n;
    wait_n = gaps ? (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18)) : 0;
    repeat (wait_n) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= g;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_entry();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000 ^ $urandom_range(0, 1);
      1: return 32'h7FFF_FFFF - $urandom_range(0, 1);
      2: return $urandom_range(0, 3) << 16;
      3: return $urandom & 32'h0003_FFFF;
      4: return -($urandom & 32'h0003_FFFF);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [191:0] rand_matrix();
    logic [191:0] g;
    for (int k = 0; k < 6; k++) g[32*k +: 32] = rand_entry();
    case ($urandom_range(0, 7))
      0: begin
        g[63:32] = g[31:0]; g[127:96] = g[31:0];
        g[95:64] = g[31:0]; g[159:128] = g[31:0]; g[191:160] = g[31:0];
      end
      1: g[31:0] = '0;
      2: begin g[63:32] = '0; g[95:64] = '0; g[159:128] = '0; end
      default: ;
    endcase
    return g;
  endfunction

  localparam logic [31:0] ONE = 32'h0001_0000;

  initial begin
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    s_tvalid = 1'b0; s_tdata = '0; copy_only = 1'b0; hold_req = 1'b0;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_matrix({ONE, 32'h0, 32'h0, ONE, 32'h0, ONE}, 1'b0);
    send_matrix({32'h2_0000, 32'h0, 32'h0, 32'h4_0000, 32'h0, 32'h8_0000}, 1'b0);
    send_matrix('0, 1'b0);
    send_matrix({6{32'h8000_0000}}, 1'b0);
    send_matrix({6{32'h7FFF_FFFF}}, 1'b0);
    send_matrix({32'h7FFF_FFFF, 32'h0, 32'h0, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF}, 1'b0);
    send_matrix({32'h1, 32'h0, 32'h0, 32'h1, 32'h0, 32'h1}, 1'b0);
    send_matrix({32'hFFFF_FFFF, 32'h0, 32'h0, 32'h1, 32'h0, 32'h1}, 1'b0);
    send_matrix({ONE, ONE, 32'h0, 32'h2_0000, ONE, 32'h3_0000}, 1'b0);
    send_matrix({-ONE, 32'h8000, 32'h4000, -ONE, 32'h2000, -ONE}, 1'b0);
    drain();

    apb_write(32'h1);
    send_matrix({6{32'h8000_0000}}, 1'b0);
    send_matrix({6{32'h7FFF_FFFF}}, 1'b0);
    send_matrix('0, 1'b0);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      apb_write(32'(phase % 2 == 1) | ($urandom & 32'hFFFF_FFFE));
      for (int n = 0; n < 450; n++) begin
        if (phase == 2 && n == 100) hold_req = 1'b1;
        send_matrix(rand_matrix(), (phase != 2 && n % 150 > 40));
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
